@@ hw/rtl/bhsr_pkg.sv @@
// Shared constants and types for the byte histogram with sorted readout.
// Holds bin geometry, action codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package bhsr_pkg;

  localparam int NUM_BINS   = 128;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 7;
  localparam int TALLY_W    = 16;
  localparam int ACT_W      = 2;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [ACT_W-1:0] {
    ACT_COUNT = 2'd0,
    ACT_FETCH = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef struct packed {
    logic cfg_wr;
    logic latch;
    logic cnt_wr;
    logic clear;
    logic scan_init;
    logic scan_rd;
    logic load_out;
  } bhsr_cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_last;
    logic out_busy;
  } bhsr_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bhsr_ctrl.sv @@
// Controller state machine for the byte histogram.
// Sequences count, clear and scan operations; drives datapath commands.
// Depends on bhsr_pkg.
`default_nettype none

module bhsr_ctrl
  import bhsr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [ACT_W-1:0] in_action,
  output logic                  in_ready,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire bhsr_sts_t        sts,
  output bhsr_cmd_t             cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  act_t   action;

  assign action    = act_t'(in_action);
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.cfg_wr    = cfg_valid && cfg_ready;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          unique case (action)
            ACT_COUNT: begin
              if (sts.in_range) state_next = ST_CNT_WR;
            end
            ACT_FETCH: begin
              cmd.scan_init = 1'b1;
              state_next    = ST_SCAN;
            end
            ACT_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cnt_wr, cmd.clear, cmd.scan_rd, cmd.load_out, cmd.scan_init}))
    else $error("bhsr_ctrl: conflicting datapath commands");

  a_scan_to_result: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_init |=> !in_ready)
    else $error("bhsr_ctrl: input accepted during a fetch");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> state == ST_RESULT && !sts.out_busy)
    else $error("bhsr_ctrl: result loaded into a full output register");

endmodule

`default_nettype wire

@@ hw/rtl/bhsr_datapath.sv @@
// Datapath for the byte histogram: bin memory with valid bits, scan compare,
// listing cursor, mode register and output register.
// Depends on bhsr_pkg.
`default_nettype none

module bhsr_datapath
  import bhsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bhsr_cmd_t         cmd,
  output bhsr_sts_t              sts,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              cfg_data,
  input  wire logic              out_ready,
  output logic                   out_vld,
  output logic                   out_entry,
  output logic [SYM_W-1:0]       out_sym,
  output logic [TALLY_W-1:0]     out_tally
);

  logic [COUNT_BITS-1:0] bins_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_vld;

  logic [BIN_W-1:0]      byte_addr;
  logic [BIN_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_vld;
  logic [BIN_W-1:0]      scan_idx;
  logic [BIN_W-1:0]      cmp_idx;
  logic                  cmp_en;

  logic                  order_mode;
  logic                  started;
  logic [COUNT_BITS-1:0] cur_t;
  logic [BIN_W-1:0]      cur_sym;

  logic                  best_found;
  logic [COUNT_BITS-1:0] best_t;
  logic [BIN_W-1:0]      best_sym;

  logic [COUNT_BITS-1:0] cand_t;
  logic [COUNT_BITS-1:0] inc_t;
  logic                  after_cur;
  logic                  take;

  assign sts.in_range  = {1'b0, data_byte} < (BYTE_W + 1)'(NUM_BINS);
  assign sts.scan_last = (scan_idx == BIN_W'(NUM_BINS - 1));
  assign sts.out_busy  = out_vld && !out_ready;

  assign rd_addr = cmd.scan_rd ? scan_idx : data_byte[BIN_W-1:0];
  assign cand_t  = rd_vld ? rd_data : '0;
  assign inc_t   = (cand_t == '1) ? cand_t : cand_t + 1'b1;

  always_comb begin
    if (!started) begin
      after_cur = 1'b1;
    end else if (!order_mode) begin
      after_cur = cmp_idx > cur_sym;
    end else begin
      after_cur = (cand_t < cur_t) || (cand_t == cur_t && cmp_idx > cur_sym);
    end
  end

  assign take = cmp_en && (cand_t != '0) && after_cur &&
                (!best_found || (order_mode && cand_t > best_t));

  always_ff @(posedge clk) begin
    rd_data <= bins_mem[rd_addr];
    if (cmd.cnt_wr) bins_mem[byte_addr] <= inc_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
    end else if (cmd.clear) begin
      bin_vld <= '0;
    end else if (cmd.cnt_wr) begin
      bin_vld[byte_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld  <= bin_vld[rd_addr];
    cmp_idx <= scan_idx;
    if (cmd.latch) byte_addr <= data_byte[BIN_W-1:0];
    if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (take) begin
      best_t   <= cand_t;
      best_sym <= cmp_idx;
    end
    if (cmd.load_out && best_found) begin
      cur_t   <= best_t;
      cur_sym <= best_sym;
    end
    if (cmd.load_out) begin
      out_entry <= best_found;
      out_sym   <= best_found ? SYM_W'(best_sym) : '0;
      out_tally <= best_found ? TALLY_W'(best_t) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en     <= 1'b0;
      best_found <= 1'b0;
      order_mode <= 1'b0;
      started    <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
      if (cmd.scan_init) begin
        best_found <= 1'b0;
      end else if (take) begin
        best_found <= 1'b1;
      end
      if (cmd.cfg_wr) begin
        order_mode <= cfg_data;
      end
      if (cmd.cfg_wr || cmd.clear || cmd.cnt_wr) begin
        started <= 1'b0;
      end else if (cmd.load_out && best_found) begin
        started <= 1'b1;
      end
      if (cmd.load_out) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> bin_vld == '0)
    else $error("bhsr_datapath: bins not empty after clear");

  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_wr |=> bin_vld[$past(byte_addr)])
    else $error("bhsr_datapath: counted bin not marked valid");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && best_found |=> started && out_entry && cur_t != '0)
    else $error("bhsr_datapath: listed entry with zero tally");

endmodule

`default_nettype wire

@@ hw/rtl/byte_histogram_sorted_readout_unit.sv @@
// Byte histogram with sorted readout, top level.
// Input words on s_axis carry an action in tuser and a byte in tdata.
// Result words on m_axis are returned for fetch actions only.
// A count reads its bin when the word is taken, then writes the saturating
// increment back from ST_CNT_WR; clear and ignored words are done as they are
// taken. A fetch scans every bin through the single memory read port, one bin
// per cycle, then passes a drain state and loads its result into the output
// register from ST_RESULT, after which the next input word can be taken.
// One input word is in work at a time; s_axis_tready is high while idle.
// The output register holds a finished result while the next input words
// are taken; a fetch waits at its end only while that register is still full
// and m_axis_tready is low. Stalls on m_axis never drop or repeat a result.
// cfg_data writes the ordering mode (0 ascending symbol, 1 descending count)
// and restarts the listing; cfg_ready is high while idle.
// Reset (rst, synchronous) empties all bins at once through per-bin valid
// flags, clears the mode to 0 and restarts the listing; no clearing pass.
// Depends on bhsr_pkg, bhsr_ctrl, bhsr_datapath.
`default_nettype none

module byte_histogram_sorted_readout_unit
  import bhsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // data_byte
  input  wire logic [ACT_W-1:0]      s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // symbol, tally, zero pad
  output logic                       m_axis_tuser,  // entry_valid
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data       // order_mode
);

  bhsr_cmd_t          cmd;
  bhsr_sts_t          sts;
  logic [SYM_W-1:0]   out_sym;
  logic [TALLY_W-1:0] out_tally;

  bhsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhsr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .data_byte (s_axis_tdata),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_vld   (m_axis_tvalid),
    .out_entry (m_axis_tuser),
    .out_sym   (out_sym),
    .out_tally (out_tally)
  );

  assign m_axis_tdata = {(OUT_DATA_W - SYM_W - TALLY_W)'(0), out_tally, out_sym};

endmodule

`default_nettype wire
